[src/psbtgmp_pkg.sv]
// ----------------------------------------------------------------------------
// psbtgmp_pkg
// Shared types and constants for the PSBT global map parser: parse phases,
// event and status codes, the result record and the magic byte table.
// ----------------------------------------------------------------------------
`default_nettype none

package psbtgmp_pkg;

  // Width of the length fields on the result channel
  localparam int FLEN_W = 17;

  // Compact-size prefixes
  localparam logic [7:0] CS_PREFIX_2 = 8'd253;
  localparam logic [7:0] CS_PREFIX_4 = 8'd254;
  localparam logic [7:0] SEPARATOR   = 8'h00;

  // Parse phases
  typedef enum logic [2:0] {
    PH_MAGIC = 3'd0,
    PH_BOUND = 3'd1,
    PH_KLEN  = 3'd2,
    PH_KEY   = 3'd3,
    PH_VLEN0 = 3'd4,
    PH_VLEN  = 3'd5,
    PH_VAL   = 3'd6,
    PH_DONE  = 3'd7
  } phase_t;

  // Event kinds
  localparam logic [1:0] EV_RECORD = 2'd0;
  localparam logic [1:0] EV_SEP    = 2'd1;
  localparam logic [1:0] EV_STATUS = 2'd2;

  // Final status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_LONG      = 3'd2;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // One result record
  typedef struct packed {
    logic [1:0]        event_kind;
    logic [7:0]        key_kind;
    logic [FLEN_W-1:0] key_length;
    logic [FLEN_W-1:0] value_length;
    logic [2:0]        status;
    logic              last_result;
  } result_t;

  // Results produced by one input byte (zero, one or two)
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // Magic sequence 'p' 's' 'b' 't' 0xff
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h70;
      3'd1:    b = 8'h73;
      3'd2:    b = 8'h62;
      3'd3:    b = 8'h74;
      default: b = 8'hff;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[src/psbtgmp_core.sv]
// ----------------------------------------------------------------------------
// psbtgmp_core
// Byte-serial parse state: magic check, compact-size decode, key and value
// walk, byte counting and final status. Produces up to two results a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module psbtgmp_core #(
  parameter int MAX_BYTES = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_data,
  output psbtgmp_pkg::push_t      push
);

  localparam int LEN_W  = $clog2(MAX_BYTES + 2);
  localparam int SUM_W  = LEN_W + 25;
  localparam int FLEN_W = psbtgmp_pkg::FLEN_W;
  localparam logic [LEN_W-1:0] SAT_LEN = LEN_W'(MAX_BYTES + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);

  psbtgmp_pkg::phase_t phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] size_accumulator, size_accumulator_next;
  logic [3:0]       size_bytes_left, size_bytes_left_next;
  logic [3:0]       size_index, size_index_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]       held_key_kind, held_key_kind_next;
  logic [LEN_W-1:0] held_key_length, held_key_length_next;
  logic             bad_magic_seen, bad_magic_seen_next;
  logic             truncated_seen, truncated_seen_next;

  logic             sep, record, first_done, more_done;
  logic [LEN_W-1:0] first_acc, more_acc;
  logic [3:0]       first_left;
  logic [SUM_W-1:0] shifted, sum;
  logic [2:0]       status;
  psbtgmp_pkg::result_t rec_res, sep_res, st_res;

  // Decode the first byte of a compact size
  always_comb begin
    first_done = (data_byte < psbtgmp_pkg::CS_PREFIX_2);
    first_acc  = (SUM_W'(data_byte) > SUM_W'(SAT_LEN)) ? SAT_LEN : LEN_W'(data_byte);
    if (data_byte == psbtgmp_pkg::CS_PREFIX_2) begin
      first_left = 4'd2;
    end else if (data_byte == psbtgmp_pkg::CS_PREFIX_4) begin
      first_left = 4'd4;
    end else begin
      first_left = 4'd8;
    end
  end

  // Fold one more little-endian byte into the size, saturating
  always_comb begin
    case (size_index)
      4'd0:    shifted = SUM_W'(data_byte);
      4'd1:    shifted = SUM_W'({data_byte, 8'h00});
      default: shifted = SUM_W'({data_byte, 16'h0000});
    endcase
    sum = SUM_W'(size_accumulator) + shifted;
    if (size_index >= 4'd3) begin
      more_acc = (data_byte != 8'h00) ? SAT_LEN : size_accumulator;
    end else begin
      more_acc = (sum > SUM_W'(SAT_LEN)) ? SAT_LEN : sum[LEN_W-1:0];
    end
    more_done = (size_bytes_left <= 4'd1);
  end

  // Next state for one accepted byte
  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    size_accumulator_next = size_accumulator;
    size_bytes_left_next  = size_bytes_left;
    size_index_next       = size_index;
    bytes_left_next       = bytes_left;
    held_key_kind_next    = held_key_kind;
    held_key_length_next  = held_key_length;
    bad_magic_seen_next   = bad_magic_seen;
    truncated_seen_next   = truncated_seen;
    sep                   = 1'b0;
    record                = 1'b0;
    status                = psbtgmp_pkg::ST_OK;

    case (phase)
      psbtgmp_pkg::PH_MAGIC: begin
        if (byte_count < LEN_W'(5)) begin
          if (data_byte != psbtgmp_pkg::magic_byte(byte_count[2:0])) begin
            bad_magic_seen_next = 1'b1;
          end
          if (byte_count == LEN_W'(4)) begin
            phase_next = bad_magic_seen_next ? psbtgmp_pkg::PH_DONE
                                             : psbtgmp_pkg::PH_BOUND;
          end
        end else begin
          phase_next = psbtgmp_pkg::PH_DONE;
        end
      end
      psbtgmp_pkg::PH_BOUND: begin
        if (data_byte == psbtgmp_pkg::SEPARATOR) begin
          sep        = 1'b1;
          phase_next = psbtgmp_pkg::PH_DONE;
        end else begin
          size_index_next       = 4'd0;
          size_accumulator_next = first_done ? first_acc : '0;
          size_bytes_left_next  = first_done ? 4'd0 : first_left;
          if (first_done) begin
            held_key_length_next = first_acc;
            bytes_left_next      = first_acc;
            held_key_kind_next   = 8'h00;
            phase_next = (first_acc == '0) ? psbtgmp_pkg::PH_VLEN0 : psbtgmp_pkg::PH_KEY;
          end else begin
            phase_next = psbtgmp_pkg::PH_KLEN;
          end
        end
      end
      psbtgmp_pkg::PH_KLEN: begin
        size_accumulator_next = more_acc;
        size_index_next       = size_index + 4'd1;
        if (size_bytes_left != 4'd0) begin
          size_bytes_left_next = size_bytes_left - 4'd1;
        end
        if (more_done) begin
          held_key_length_next = more_acc;
          bytes_left_next      = more_acc;
          held_key_kind_next   = 8'h00;
          phase_next = (more_acc == '0) ? psbtgmp_pkg::PH_VLEN0 : psbtgmp_pkg::PH_KEY;
        end
      end
      psbtgmp_pkg::PH_KEY: begin
        if (bytes_left == held_key_length) begin
          held_key_kind_next = data_byte;
        end
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LEN_W'(1);
        end
        if (bytes_left_next == '0) begin
          phase_next = psbtgmp_pkg::PH_VLEN0;
        end
      end
      psbtgmp_pkg::PH_VLEN0: begin
        size_index_next       = 4'd0;
        size_accumulator_next = first_done ? first_acc : '0;
        size_bytes_left_next  = first_done ? 4'd0 : first_left;
        if (first_done) begin
          bytes_left_next = first_acc;
          record          = (first_acc == '0);
          phase_next = record ? psbtgmp_pkg::PH_BOUND : psbtgmp_pkg::PH_VAL;
        end else begin
          phase_next = psbtgmp_pkg::PH_VLEN;
        end
      end
      psbtgmp_pkg::PH_VLEN: begin
        size_accumulator_next = more_acc;
        size_index_next       = size_index + 4'd1;
        if (size_bytes_left != 4'd0) begin
          size_bytes_left_next = size_bytes_left - 4'd1;
        end
        if (more_done) begin
          bytes_left_next = more_acc;
          record          = (more_acc == '0);
          phase_next = record ? psbtgmp_pkg::PH_BOUND : psbtgmp_pkg::PH_VAL;
        end
      end
      psbtgmp_pkg::PH_VAL: begin
        if (bytes_left != '0) begin
          bytes_left_next = bytes_left - LEN_W'(1);
        end
        if (bytes_left_next == '0) begin
          record     = 1'b1;
          phase_next = psbtgmp_pkg::PH_BOUND;
        end
      end
      default: begin
      end
    endcase

    // Count bytes, saturating one past the limit
    if (byte_count < SAT_LEN) begin
      byte_count_next = byte_count + LEN_W'(1);
    end

    // Grade the stream on its final byte
    if (phase_next == psbtgmp_pkg::PH_KLEN || phase_next == psbtgmp_pkg::PH_KEY ||
        phase_next == psbtgmp_pkg::PH_VLEN0 || phase_next == psbtgmp_pkg::PH_VLEN ||
        phase_next == psbtgmp_pkg::PH_VAL) begin
      truncated_seen_next = truncated_seen | end_of_data;
    end
    if (byte_count_next > MAX_LEN) begin
      status = psbtgmp_pkg::ST_LONG;
    end else if (byte_count_next < LEN_W'(5)) begin
      status = psbtgmp_pkg::ST_SHORT;
    end else if (bad_magic_seen_next) begin
      status = psbtgmp_pkg::ST_BAD_MAGIC;
    end else if (truncated_seen_next) begin
      status = psbtgmp_pkg::ST_TRUNC;
    end

    // Return to the reset state after the final byte
    if (end_of_data) begin
      phase_next            = psbtgmp_pkg::PH_MAGIC;
      byte_count_next       = '0;
      size_accumulator_next = '0;
      size_bytes_left_next  = 4'd0;
      size_index_next       = 4'd0;
      bytes_left_next       = '0;
      held_key_kind_next    = 8'h00;
      held_key_length_next  = '0;
      bad_magic_seen_next   = 1'b0;
      truncated_seen_next   = 1'b0;
    end
  end

  // Build the result records
  always_comb begin
    rec_res              = '0;
    rec_res.event_kind   = psbtgmp_pkg::EV_RECORD;
    rec_res.key_kind     = held_key_kind;
    rec_res.key_length   = FLEN_W'(held_key_length);
    rec_res.value_length = FLEN_W'(phase == psbtgmp_pkg::PH_VAL ? size_accumulator
                           : (phase == psbtgmp_pkg::PH_VLEN ? more_acc : first_acc));
    sep_res              = '0;
    sep_res.event_kind   = psbtgmp_pkg::EV_SEP;
    st_res               = '0;
    st_res.event_kind    = psbtgmp_pkg::EV_STATUS;
    st_res.status        = status;
    st_res.last_result   = 1'b1;

    push = '0;
    if (accept) begin
      push.count  = 2'({1'b0, sep | record}) + 2'({1'b0, end_of_data});
      push.first  = sep ? sep_res : (record ? rec_res : st_res);
      push.second = st_res;
    end
  end

  // Hold the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= psbtgmp_pkg::PH_MAGIC;
      byte_count       <= '0;
      size_accumulator <= '0;
      size_bytes_left  <= 4'd0;
      size_index       <= 4'd0;
      bytes_left       <= '0;
      held_key_kind    <= 8'h00;
      held_key_length  <= '0;
      bad_magic_seen   <= 1'b0;
      truncated_seen   <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      size_accumulator <= size_accumulator_next;
      size_bytes_left  <= size_bytes_left_next;
      size_index       <= size_index_next;
      bytes_left       <= bytes_left_next;
      held_key_kind    <= held_key_kind_next;
      held_key_length  <= held_key_length_next;
      bad_magic_seen   <= bad_magic_seen_next;
      truncated_seen   <= truncated_seen_next;
    end
  end

  // Final byte leaves the parser in its reset state
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_data |=> phase == psbtgmp_pkg::PH_MAGIC && byte_count == '0)
    else $error("parser state not cleared after final byte");

  // Two results only when a record or separator meets the final byte
  a_two_is_status: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.second.event_kind == psbtgmp_pkg::EV_STATUS &&
                           push.first.event_kind != psbtgmp_pkg::EV_STATUS)
    else $error("double result without trailing status");

  // No result without an accepted byte
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !accept |-> push.count == 2'd0)
    else $error("result produced without a byte transfer");

endmodule

`default_nettype wire

[src/psbtgmp_fifo.sv]
// ----------------------------------------------------------------------------
// psbtgmp_fifo
// Four-entry result queue. Takes up to two results a cycle from the parser
// and drives them one per transfer on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module psbtgmp_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire psbtgmp_pkg::push_t   push,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output psbtgmp_pkg::result_t      out_res
);

  localparam int DEPTH = 4;

  psbtgmp_pkg::result_t entries [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  // Accept a byte only with space for two results
  assign room      = (count <= 3'(DEPTH - 2));
  assign out_valid = (count != 3'd0);
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count + 3'(push.count) - 3'({2'b00, pop});
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= 3'(DEPTH - 2))
    else $error("result pushed without space");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH))
    else $error("result queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - 3'd1)
    else $error("occupancy not reduced on transfer");

endmodule

`default_nettype wire

[src/psbt_global_map_parser.sv]
// ----------------------------------------------------------------------------
// psbt_global_map_parser
// Byte-stream parser for the global key-value map of a PSBT stream.
//
// Input channel s_*: one byte per transfer, s_tlast on the final byte.
// Output channel m_*: one result per transfer; m_tuser gives the event
// (record, separator, final status), m_tlast marks the final status.
// The parser checks the 5-byte magic, decodes each record's compact-size
// key and value lengths and reports every record, the map separator and
// a final status on the last byte of the stream.
// Throughput: one byte per cycle while s_tready is high; the state update
// for each byte is done in the cycle it is accepted. Results are registered
// in the queue before they reach m_*. A byte can cause two results (record
// or separator plus final status); these leave through a four-entry queue
// one per cycle while m_tready is high, and s_tready drops while fewer than
// two entries are free. When the receiver stalls, results wait in the queue
// and input is held off once it fills. Reset clears parse state and empties
// the queue; the final byte returns the parse state to reset for a new stream.
// ----------------------------------------------------------------------------
`default_nettype none

module psbt_global_map_parser #(
  parameter int MAX_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_data
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [7:0] first key byte, [24:8] key_length,
                                      // [41:25] value_length, [44:42] status
  output logic [1:0]       m_tuser,   // event_kind
  output logic             m_tlast    // last_result
);

  psbtgmp_pkg::push_t   push;
  psbtgmp_pkg::result_t res;
  logic                 accept;

  assign accept = s_tvalid && s_tready;

  // Parse state and result build
  psbtgmp_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .end_of_data (s_tlast),
    .push        (push)
  );

  // Result queue
  psbtgmp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack the result channel
  assign m_tdata = {3'b000, res.status, res.value_length, res.key_length, res.key_kind};
  assign m_tuser = res.event_kind;
  assign m_tlast = res.last_result;

endmodule

`default_nettype wire
